### hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, off while reset is high
`define MBPC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be true outside reset
`define MBPC_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### hw/rtl/mbpc_pkg.sv
`timescale 1ns / 1ps

package mbpc_pkg;

  // sizes
  localparam int NUM_TAGS_DEFAULT = 32;
  localparam int MAX_LANES        = 32;
  localparam int SHIFTS_PER_BYTE  = 8;
  localparam int WORD_W           = 32;
  localparam int SLOT_W           = 5;
  localparam int LEN_W            = 6;
  localparam int SKIP_W           = 5;
  localparam int CNT_W            = 32;
  localparam int CFG_W            = 6;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // input commands
  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_BYTE = 2'd1,
    CMD_DUMP = 2'd2
  } cmd_t;

  // control sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_SCAN,
    ST_DRAIN,
    ST_DUMP_RD,
    ST_DUMP_LD
  } state_t;

  // aligned tag written into a lane
  typedef struct packed {
    logic              vld;
    logic [SLOT_W-1:0] idx;
    logic [WORD_W-1:0] pattern;
    logic [WORD_W-1:0] mask;
    logic [LEN_W-1:0]  length;
  } tag_load_t;

  // winner of one shift position
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
  } scan_hit_t;

endpackage

### hw/rtl/masked_bit_pattern_counter_unit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// channel   | handshake              | payload
// ----------+------------------------+------------------------------------------
// config    | cfg_wr_en              | cfg_wr_data (tags in use)
// input     | in_valid / in_ready    | cmd, data_byte, tag_slot, tag_pattern, tag_mask
// output    | out_valid / out_ready  | tag_number, hit_count, last_of_run
//
// tag load: one bit of alignment shift per cycle
// window byte: only shifted in while filling, else 8 shift positions are scanned, one per cycle,
//   then a drain state finishes the last count read-modify-write through the count ram
// dump: per count, a ram read state then an output load state that waits while out_valid is high and out_ready is low
// reset clears control state; counts read as zero through per-entry valid bits
module masked_bit_pattern_counter_unit #(
  parameter int NUM_TAGS = mbpc_pkg::NUM_TAGS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [mbpc_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    cmd,
  input  logic [7:0]                    data_byte,
  input  logic [mbpc_pkg::SLOT_W-1:0]   tag_slot,
  input  logic [mbpc_pkg::WORD_W-1:0]   tag_pattern,
  input  logic [mbpc_pkg::WORD_W-1:0]   tag_mask,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mbpc_pkg::SLOT_W-1:0]   tag_number,
  output logic [mbpc_pkg::CNT_W-1:0]    hit_count,
  output logic                          last_of_run
);
  import mbpc_pkg::*;

  localparam int LANES = (NUM_TAGS < MAX_LANES) ? NUM_TAGS : MAX_LANES;
  localparam int IW    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int SH_W  = $clog2(SHIFTS_PER_BYTE);
  localparam logic [CFG_W-1:0] LANES_N  = CFG_W'(LANES);
  localparam logic [SH_W-1:0]  LAST_SH  = SH_W'(SHIFTS_PER_BYTE - 1);

  state_t            state;
  state_t            state_next;
  logic [CFG_W-1:0]  tags_in_use;
  logic [CFG_W-1:0]  n_eff;
  logic [WORD_W-1:0] win;
  logic [1:0]        bytes_seen;
  logic [WORD_W-1:0] scan_bits;
  logic [SH_W-1:0]   shift_cnt;
  logic [CFG_W-1:0]  dump_idx;
  logic [LANES-1:0]  cnt_valid;

  logic              in_fire;
  cmd_t              cmd_in;
  logic              slot_ok;
  logic              window_full;
  logic              dump_last;
  logic              out_free;

  logic              scan_en;
  logic              align_start;
  logic              byte_take;
  logic              dump_load;
  logic              dump_clear;

  tag_load_t         ld;
  scan_hit_t         hit;

  logic [IW-1:0]     ram_raddr;
  logic [CNT_W-1:0]  ram_rdata;
  logic              rd_ok;
  logic              upd_vld;
  logic [IW-1:0]     upd_idx;
  logic              fwd_vld;
  logic [IW-1:0]     fwd_idx;
  logic [CNT_W-1:0]  fwd_data;
  logic [CNT_W-1:0]  cnt_old;
  logic [CNT_W-1:0]  cnt_new;

  // decode
  assign in_ready    = (state == ST_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign cmd_in      = cmd_t'(cmd);
  assign n_eff       = (tags_in_use > LANES_N) ? LANES_N : tags_in_use;
  assign slot_ok     = ({1'b0, tag_slot} < LANES_N);
  assign window_full = (bytes_seen == 2'd3);
  assign dump_last   = ((dump_idx + CFG_W'(1)) == n_eff);
  assign out_free    = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (cmd_in)
            CMD_LOAD: if (slot_ok) state_next = ST_ALIGN;
            CMD_BYTE: if (window_full) state_next = ST_SCAN;
            CMD_DUMP: if (n_eff != '0) state_next = ST_DUMP_RD;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_ALIGN:   if (ld.vld) state_next = ST_IDLE;
      ST_SCAN:    if (shift_cnt == LAST_SH) state_next = ST_DRAIN;
      ST_DRAIN:   state_next = ST_IDLE;
      ST_DUMP_RD: state_next = ST_DUMP_LD;
      ST_DUMP_LD: begin
        if (out_free) begin
          state_next = dump_last ? ST_IDLE : ST_DUMP_RD;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    scan_en     = (state == ST_SCAN);
    align_start = in_fire && (cmd_in == CMD_LOAD) && slot_ok;
    byte_take   = in_fire && (cmd_in == CMD_BYTE);
    dump_load   = (state == ST_DUMP_LD) && out_free;
    dump_clear  = (dump_load && dump_last) ||
                  (in_fire && (cmd_in == CMD_DUMP) && (n_eff == '0));
    if (state == ST_DUMP_RD || state == ST_DUMP_LD) begin
      ram_raddr = dump_idx[IW-1:0];
    end else begin
      ram_raddr = hit.idx[IW-1:0];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      tags_in_use <= CFG_W'(32);
      win         <= '0;
      bytes_seen  <= '0;
      shift_cnt   <= '0;
      dump_idx    <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        tags_in_use <= cfg_wr_data;
      end
      if (byte_take) begin
        win <= {win[WORD_W-9:0], data_byte};
        if (!window_full) begin
          bytes_seen <= bytes_seen + 2'd1;
        end
      end else if (dump_clear) begin
        win        <= '0;
        bytes_seen <= '0;
      end
      if (scan_en) begin
        shift_cnt <= shift_cnt + SH_W'(1);
      end else begin
        shift_cnt <= '0;
      end
      if (in_fire) begin
        dump_idx <= '0;
      end else if (dump_load) begin
        dump_idx <= dump_idx + CFG_W'(1);
      end
    end
  end

  // shifted window, one bit per scan cycle
  always_ff @(posedge clk) begin
    if (byte_take) begin
      scan_bits <= {win[WORD_W-9:0], data_byte};
    end else if (scan_en) begin
      scan_bits <= scan_bits << 1;
    end
  end

  mbpc_tag_align u_align (
    .clk     (clk),
    .rst     (rst),
    .start   (align_start),
    .slot    (tag_slot),
    .pattern (tag_pattern),
    .mask    (tag_mask),
    .load    (ld)
  );

  mbpc_tag_lanes #(
    .LANES (LANES)
  ) u_lanes (
    .clk       (clk),
    .rst       (rst),
    .load      (ld),
    .scan_en   (scan_en),
    .scan_bits (scan_bits),
    .n_eff     (n_eff),
    .hit       (hit)
  );

  mbpc_count_ram #(
    .DEPTH (LANES),
    .AW    (IW),
    .DW    (CNT_W)
  ) u_ram (
    .clk   (clk),
    .we    (upd_vld),
    .waddr (upd_idx),
    .wdata (cnt_new),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // count update, forwarding the write made at the read edge
  always_comb begin
    if (fwd_vld && fwd_idx == upd_idx) begin
      cnt_old = fwd_data;
    end else if (rd_ok) begin
      cnt_old = ram_rdata;
    end else begin
      cnt_old = '0;
    end
    cnt_new = (cnt_old == CNT_MAX) ? cnt_old : cnt_old + CNT_W'(1);
  end

  // update stage and entry valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      upd_vld   <= 1'b0;
      fwd_vld   <= 1'b0;
      cnt_valid <= '0;
      rd_ok     <= 1'b0;
    end else begin
      upd_vld <= scan_en && hit.found;
      fwd_vld <= upd_vld;
      rd_ok   <= cnt_valid[ram_raddr];
      if (dump_clear) begin
        cnt_valid <= '0;
      end else if (upd_vld) begin
        cnt_valid[upd_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    upd_idx  <= hit.idx[IW-1:0];
    fwd_idx  <= upd_idx;
    fwd_data <= cnt_new;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dump_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dump_load) begin
      tag_number  <= SLOT_W'(dump_idx);
      hit_count   <= rd_ok ? ram_rdata : '0;
      last_of_run <= dump_last;
    end
  end

  `MBPC_ASSERT(a_upd_after_scan, clk, rst, upd_vld |-> ($past(state) == ST_SCAN), "count write without scan")
  `MBPC_ASSERT(a_dump_idx_range, clk, rst, (state == ST_DUMP_RD) |-> (dump_idx < n_eff), "dump index past active tags")

endmodule

### hw/rtl/mbpc_count_ram.sv
`timescale 1ns / 1ps

module mbpc_count_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/mbpc_tag_align.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbpc_tag_align (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mbpc_pkg::SLOT_W-1:0]   slot,
  input  logic [mbpc_pkg::WORD_W-1:0]   pattern,
  input  logic [mbpc_pkg::WORD_W-1:0]   mask,
  output mbpc_pkg::tag_load_t           load
);
  import mbpc_pkg::*;

  logic              busy;
  logic [WORD_W-1:0] pat_r;
  logic [WORD_W-1:0] msk_r;
  logic [SLOT_W-1:0] idx_r;
  logic [LEN_W-1:0]  steps;
  logic              done;
  logic              msk_zero;

  // finished once the mask top bit is set or the mask is empty
  assign msk_zero = (msk_r == '0);
  assign done     = busy && (msk_zero || msk_r[WORD_W-1]);

  // aligned tag handed to the lanes
  always_comb begin
    load.vld     = done;
    load.idx     = idx_r;
    load.mask    = msk_r;
    load.pattern = msk_zero ? '0 : pat_r;
    load.length  = msk_zero ? '0 : (LEN_W'(WORD_W) - steps);
  end

  // busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  // one bit of left shift per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      pat_r <= pattern;
      msk_r <= mask;
      idx_r <= slot;
      steps <= '0;
    end else if (busy && !done) begin
      pat_r <= pat_r << 1;
      msk_r <= msk_r << 1;
      steps <= steps + LEN_W'(1);
    end
  end

  `MBPC_ASSERT(a_len_top_bit, clk, rst, (load.vld && load.length != '0) |-> load.mask[WORD_W-1], "aligned mask lacks top bit")
  `MBPC_NEVER(a_start_busy, clk, rst, start && busy, "tag load started while aligning")

endmodule

### hw/rtl/mbpc_tag_lanes.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbpc_tag_lanes #(
  parameter int LANES = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mbpc_pkg::tag_load_t           load,
  input  logic                          scan_en,
  input  logic [mbpc_pkg::WORD_W-1:0]   scan_bits,
  input  logic [mbpc_pkg::CFG_W-1:0]    n_eff,
  output mbpc_pkg::scan_hit_t           hit
);
  import mbpc_pkg::*;

  localparam int IW = (LANES > 1) ? $clog2(LANES) : 1;

  logic [WORD_W-1:0] pat_q  [LANES];
  logic [WORD_W-1:0] mask_q [LANES];
  logic [LEN_W-1:0]  len_q  [LANES];
  logic [SKIP_W-1:0] skip_q [LANES];
  logic [LANES-1:0]  active;
  logic [LANES-1:0]  match;
  logic [IW-1:0]     best;
  logic              found;

  // per-lane compare against the shifted window
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      active[i] = (CFG_W'(i) < n_eff);
      match[i]  = active[i] && (skip_q[i] == '0) &&
                  (((scan_bits ^ pat_q[i]) & mask_q[i]) == '0);
    end
  end

  // highest matching lane wins
  always_comb begin
    found = 1'b0;
    best  = '0;
    for (int i = 0; i < LANES; i++) begin
      if (match[i]) begin
        found = 1'b1;
        best  = IW'(i);
      end
    end
    hit.found = found;
    hit.idx   = SLOT_W'(best);
  end

  // tag storage
  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      if (load.vld && load.idx[IW-1:0] == IW'(i)) begin
        pat_q[i]  <= load.pattern;
        mask_q[i] <= load.mask;
        len_q[i]  <= load.length;
      end
    end
  end

  // skip counters, one step per shift position
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANES; i++) begin
        skip_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < LANES; i++) begin
        if (load.vld && load.idx[IW-1:0] == IW'(i)) begin
          skip_q[i] <= '0;
        end else if (scan_en && active[i]) begin
          if (skip_q[i] != '0) begin
            skip_q[i] <= skip_q[i] - SKIP_W'(1);
          end else if (match[i]) begin
            skip_q[i] <= SKIP_W'(len_q[i] - LEN_W'(1));
          end
        end
      end
    end
  end

  `MBPC_ASSERT(a_hit_in_range, clk, rst, hit.found |-> ({1'b0, hit.idx} < n_eff), "winner outside active tags")
  `MBPC_NEVER(a_load_scan, clk, rst, load.vld && scan_en, "tag load during scan")

endmodule
